FILE: rtl/core/ppr_pkg.sv
`default_nettype none
package ppr_pkg;

	localparam int IMG_WIDTH_DEF  = 1024;
	localparam int IMG_HEIGHT_DEF = 1024;

	localparam int COEF_W  = 32;
	localparam int NUM_REGS = 8;
	localparam int IDX_W   = 3;
	localparam int COORD_W = 10;
	localparam int PIX_W   = 8;
	localparam int PROD_W  = 43;
	localparam int NUM_W   = 46;
	localparam int FRAC_W  = 20;

	localparam logic [IDX_W-1:0] REG_SCALE_XX = 3'd0;
	localparam logic [IDX_W-1:0] REG_SHEAR_XY = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_SHEAR_YX = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCALE_YY = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_PERSP_X  = 3'd6;
	localparam logic [IDX_W-1:0] REG_PERSP_Y  = 3'd7;

	localparam logic signed [COEF_W-1:0] ONE_Q20 = 32'sd1048576;

	// side info that rides along the divider
	typedef struct packed {
		logic             den_ok;
		logic             col_neg;
		logic             row_neg;
		logic [PIX_W-1:0] pix;
	} item_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/ppr_div_step.sv
`default_nettype none
module ppr_div_step #(
	parameter int NW = 60,
	parameter int QW = 10,
	parameter int K  = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  vld_i,
	input  ppr_pkg::item_ctl_t   ctl_i,
	input  wire  [NW-1:0]        den_i,
	input  wire  [NW-1:0]        rc_i,
	input  wire  [NW-1:0]        rr_i,
	input  wire  [QW:0]          qc_i,
	input  wire  [QW:0]          qr_i,
	output logic                 vld_o,
	output ppr_pkg::item_ctl_t   ctl_o,
	output logic [NW-1:0]        den_o,
	output logic [NW-1:0]        rc_o,
	output logic [NW-1:0]        rr_o,
	output logic [QW:0]          qc_o,
	output logic [QW:0]          qr_o
);
	import ppr_pkg::*;

	logic [NW-1:0] dsh;
	logic          gc, gr;
	logic [QW:0]   qc_n, qr_n;

	always_comb begin
		dsh  = den_i << K;
		gc   = rc_i >= dsh;
		gr   = rr_i >= dsh;
		qc_n = qc_i;
		qr_n = qr_i;
		qc_n[K] = gc;
		qr_n[K] = gr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			den_o <= den_i;
			rc_o  <= gc ? rc_i - dsh : rc_i;
			rr_o  <= gr ? rr_i - dsh : rr_i;
			qc_o  <= qc_n;
			qr_o  <= qr_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/perspective_pixel_remap.sv
`default_nettype none
// pipeline from input beat to output beat: multiply, sum, magnitude, one restoring step per
//   quotient bit, clamp
// throughput: one beat per cycle; the whole pipeline holds while the output beat is not taken
// reset: arst_n clears all valid bits at once and loads the identity homography
module perspective_pixel_remap #(
	parameter int IMG_WIDTH  = ppr_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = ppr_pkg::IMG_HEIGHT_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration write
	input  wire                        cfg_wen,
	input  wire  [ppr_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [ppr_pkg::COEF_W-1:0] cfg_wdata,
	// source pixel beats
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [31:0]                s_tdata,   // src_col[9:0], src_row[19:10], pixel_value[27:20]
	// destination beats
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [31:0]                m_tdata,   // dst_col[9:0], dst_row[19:10], pixel_out[27:20]
	output logic                       m_tuser    // in_range
);
	import ppr_pkg::*;

	localparam int MAXD = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
	localparam int QW   = $clog2(MAXD);
	localparam int NW   = NUM_W + QW + 1;
	localparam logic [QW:0] W_Q    = (QW+1)'(IMG_WIDTH);
	localparam logic [QW:0] H_Q    = (QW+1)'(IMG_HEIGHT);
	localparam logic [QW:0] WMAX_Q = (QW+1)'(IMG_WIDTH - 1);
	localparam logic [QW:0] HMAX_Q = (QW+1)'(IMG_HEIGHT - 1);

	// coefficient registers
	logic signed [COEF_W-1:0] coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= '0;
			coef_q[REG_SCALE_XX] <= ONE_Q20;
			coef_q[REG_SCALE_YY] <= ONE_Q20;
		end else if (cfg_wen) begin
			coef_q[cfg_index] <= cfg_wdata;
		end
	end

	// global advance: every stage moves when the output slot frees
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [COORD_W-1:0] x_in, y_in;
	logic [PIX_W-1:0]   pix_in;
	assign x_in   = s_tdata[COORD_W-1:0];
	assign y_in   = s_tdata[2*COORD_W-1:COORD_W];
	assign pix_in = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

	// stage 1: six products
	logic signed [COEF_W:0]   xs, ys;
	logic                     vld_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic signed [PROD_W-1:0] pa_s1, pb_s1, pd_s1, pe_s1, pg_s1, ph_s1;
	logic signed [COEF_W-1:0] c_s1, f_s1;

	assign xs = {{(COEF_W-COORD_W+1){1'b0}}, x_in};
	assign ys = {{(COEF_W-COORD_W+1){1'b0}}, y_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_tvalid;
	end

	// products are formed at the full product width of the target
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pix_in;
			pa_s1  <= coef_q[REG_SCALE_XX] * xs;
			pb_s1  <= coef_q[REG_SHEAR_XY] * ys;
			pd_s1  <= coef_q[REG_SHEAR_YX] * xs;
			pe_s1  <= coef_q[REG_SCALE_YY] * ys;
			pg_s1  <= coef_q[REG_PERSP_X]  * xs;
			ph_s1  <= coef_q[REG_PERSP_Y]  * ys;
			c_s1   <= coef_q[REG_OFFSET_X];
			f_s1   <= coef_q[REG_OFFSET_Y];
		end
	end

	// stage 2: numerators and denominator, exact in q.20
	logic                    vld_s2;
	logic [PIX_W-1:0]        pix_s2;
	logic signed [NUM_W-1:0] nc_s2, nr_s2, den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2 <= pix_s1;
			nc_s2  <= NUM_W'(pa_s1) + NUM_W'(pb_s1) + NUM_W'(c_s1);
			nr_s2  <= NUM_W'(pd_s1) + NUM_W'(pe_s1) + NUM_W'(f_s1);
			den_s2 <= NUM_W'(pg_s1) + NUM_W'(ph_s1) + NUM_W'(ONE_Q20);
		end
	end

	// stage 3: magnitudes and signs for the restoring divider
	logic          vld_s3;
	item_ctl_t     ctl_s3;
	logic [NW-1:0] den_s3, rc_s3, rr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3.den_ok  <= !den_s2[NUM_W-1] && (den_s2 != '0);
			ctl_s3.col_neg <= nc_s2[NUM_W-1];
			ctl_s3.row_neg <= nr_s2[NUM_W-1];
			ctl_s3.pix     <= pix_s2;
			den_s3 <= NW'(unsigned'(den_s2));
			rc_s3  <= NW'(unsigned'(nc_s2[NUM_W-1] ? -nc_s2 : nc_s2));
			rr_s3  <= NW'(unsigned'(nr_s2[NUM_W-1] ? -nr_s2 : nr_s2));
		end
	end

	// divider: one quotient bit per stage, top bit flags a quotient beyond the image
	logic          vld_d [QW+2];
	item_ctl_t     ctl_d [QW+2];
	logic [NW-1:0] den_d [QW+2];
	logic [NW-1:0] rc_d  [QW+2];
	logic [NW-1:0] rr_d  [QW+2];
	logic [QW:0]   qc_d  [QW+2];
	logic [QW:0]   qr_d  [QW+2];

	assign vld_d[0] = vld_s3;
	assign ctl_d[0] = ctl_s3;
	assign den_d[0] = den_s3;
	assign rc_d[0]  = rc_s3;
	assign rr_d[0]  = rr_s3;
	assign qc_d[0]  = '0;
	assign qr_d[0]  = '0;

	for (genvar j = 0; j <= QW; j++) begin : g_div
		ppr_div_step #(.NW(NW), .QW(QW), .K(QW - j)) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (vld_d[j]),
			.ctl_i (ctl_d[j]),
			.den_i (den_d[j]),
			.rc_i  (rc_d[j]),
			.rr_i  (rr_d[j]),
			.qc_i  (qc_d[j]),
			.qr_i  (qr_d[j]),
			.vld_o (vld_d[j+1]),
			.ctl_o (ctl_d[j+1]),
			.den_o (den_d[j+1]),
			.rc_o  (rc_d[j+1]),
			.rr_o  (rr_d[j+1]),
			.qc_o  (qc_d[j+1]),
			.qr_o  (qr_d[j+1])
		);
	end

	// final stage: clamp into the image and form the flag
	item_ctl_t   ctl_f;
	logic [QW:0] qc_f, qr_f, col_c, row_c;
	logic        ok_c;

	assign ctl_f = ctl_d[QW+1];
	assign qc_f  = qc_d[QW+1];
	assign qr_f  = qr_d[QW+1];

	always_comb begin
		col_c = '0;
		row_c = '0;
		ok_c  = ctl_f.den_ok;
		if (ctl_f.den_ok) begin
			// negative numerator: zero quotient still lands at zero
			if (ctl_f.col_neg) begin
				if (qc_f != '0) ok_c = 1'b0;
			end else if (qc_f >= W_Q) begin
				col_c = WMAX_Q;
				ok_c  = 1'b0;
			end else begin
				col_c = qc_f;
			end
			if (ctl_f.row_neg) begin
				if (qr_f != '0) ok_c = 1'b0;
			end else if (qr_f >= H_Q) begin
				row_c = HMAX_Q;
				ok_c  = 1'b0;
			end else begin
				row_c = qr_f;
			end
		end
	end

	logic               vld_o_s;
	logic [COORD_W-1:0] col_o_s, row_o_s;
	logic [PIX_W-1:0]   pix_o_s;
	logic               ok_o_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o_s <= 1'b0;
		else if (en) vld_o_s <= vld_d[QW+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_o_s <= COORD_W'(col_c);
			row_o_s <= COORD_W'(row_c);
			pix_o_s <= ctl_f.pix;
			ok_o_s  <= ok_c;
		end
	end

	assign m_tvalid = vld_o_s;
	assign m_tdata  = {4'b0, pix_o_s, row_o_s, col_o_s};
	assign m_tuser  = ok_o_s;

	// checks
	a_inrange_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (32'(m_tdata[COORD_W-1:0]) < 32'(IMG_WIDTH)))
		else $error("in_range beat with column outside image");

	a_noden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[QW+1] && en && !ctl_f.den_ok |=> m_tvalid && !m_tuser
			&& (m_tdata[2*COORD_W-1:0] == '0))
		else $error("non-positive denominator did not give zero address");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && en |=> vld_d[1])
		else $error("beat lost entering divider");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s3))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
